// File: rtl/nsi_pkg.sv
// Shared types, constants and the step program of the Newmark integrator.
package nsi_pkg;

  localparam int DATA_W   = 64;
  localparam int FRAC_W   = 36;
  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int PADDR_W  = REG_IDX_W + 3;
  localparam int PC_W     = 5;
  localparam int TMP_N    = 4;
  localparam int TMP_W    = $clog2(TMP_N);

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic [NUM_REGS-1:0][DATA_W-1:0] coef_t;

  // micro-op codes
  typedef enum logic [2:0] {
    OP_JNA,     // jump to target when advance is clear
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_COMMIT,
    OP_DONE
  } op_t;

  // operand selects; the first eight match the register indexes
  typedef enum logic [3:0] {
    OPD_INV, OPD_DLG, OPD_VLG, OPD_ALG,
    OPD_ADG, OPD_AVG, OPD_VOAG, OPD_VNAG,
    OPD_FORCE, OPD_Y, OPD_V, OPD_A,
    OPD_T0, OPD_T1, OPD_T2, OPD_T3
  } opd_t;

  localparam logic [TMP_W-1:0] TMP_0 = 2'd0;
  localparam logic [TMP_W-1:0] TMP_1 = 2'd1;
  localparam logic [TMP_W-1:0] TMP_2 = 2'd2;
  localparam logic [TMP_W-1:0] TMP_3 = 2'd3;

  localparam logic [PC_W-1:0] PC_END = 5'd17;

  typedef struct packed {
    op_t              op;
    opd_t             src_a;
    opd_t             src_b;
    logic [TMP_W-1:0] dst;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic             mul_start;
    logic             mul_wr;
    logic             alu_wr;
    logic             alu_sub;
    logic             commit;
    logic             out_load;
    opd_t             src_a;
    opd_t             src_b;
    logic [TMP_W-1:0] dst;
  } ctrl_t;

  // T2 = new displacement, T3 = new acceleration, T1 = new velocity at commit
  function automatic uword_t nsi_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_DONE, src_a: OPD_T0, src_b: OPD_T0, dst: TMP_0, target: '0};
    case (pc)
      5'd0:  w = '{op: OP_JNA, src_a: OPD_T0, src_b: OPD_T0, dst: TMP_0, target: PC_END};
      5'd1:  w = '{op: OP_MUL, src_a: OPD_DLG, src_b: OPD_Y, dst: TMP_0, target: '0};
      5'd2:  w = '{op: OP_ADD, src_a: OPD_FORCE, src_b: OPD_T0, dst: TMP_1, target: '0};
      5'd3:  w = '{op: OP_MUL, src_a: OPD_VLG, src_b: OPD_V, dst: TMP_0, target: '0};
      5'd4:  w = '{op: OP_ADD, src_a: OPD_T1, src_b: OPD_T0, dst: TMP_1, target: '0};
      5'd5:  w = '{op: OP_MUL, src_a: OPD_ALG, src_b: OPD_A, dst: TMP_0, target: '0};
      5'd6:  w = '{op: OP_ADD, src_a: OPD_T1, src_b: OPD_T0, dst: TMP_1, target: '0};
      5'd7:  w = '{op: OP_MUL, src_a: OPD_INV, src_b: OPD_T1, dst: TMP_2, target: '0};
      5'd8:  w = '{op: OP_SUB, src_a: OPD_T2, src_b: OPD_Y, dst: TMP_0, target: '0};
      5'd9:  w = '{op: OP_MUL, src_a: OPD_ADG, src_b: OPD_T0, dst: TMP_0, target: '0};
      5'd10: w = '{op: OP_MUL, src_a: OPD_AVG, src_b: OPD_V, dst: TMP_1, target: '0};
      5'd11: w = '{op: OP_SUB, src_a: OPD_T0, src_b: OPD_T1, dst: TMP_3, target: '0};
      5'd12: w = '{op: OP_MUL, src_a: OPD_VOAG, src_b: OPD_A, dst: TMP_0, target: '0};
      5'd13: w = '{op: OP_ADD, src_a: OPD_V, src_b: OPD_T0, dst: TMP_1, target: '0};
      5'd14: w = '{op: OP_MUL, src_a: OPD_VNAG, src_b: OPD_T3, dst: TMP_0, target: '0};
      5'd15: w = '{op: OP_ADD, src_a: OPD_T1, src_b: OPD_T0, dst: TMP_1, target: '0};
      5'd16: w = '{op: OP_COMMIT, src_a: OPD_T0, src_b: OPD_T0, dst: TMP_0, target: '0};
      default: w = '{op: OP_DONE, src_a: OPD_T0, src_b: OPD_T0, dst: TMP_0, target: '0};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/nsi_if.sv
// Valid/ready channel interfaces for the integrator's input and result streams.
interface nsi_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [nsi_pkg::DATA_W-1:0]  force_req;
  logic                               advance;

  modport source (output valid, output force_req, output advance, input ready);
  modport sink   (input valid, input force_req, input advance, output ready);
endinterface

interface nsi_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [nsi_pkg::DATA_W-1:0]  displacement;
  logic signed [nsi_pkg::DATA_W-1:0]  velocity;
  logic signed [nsi_pkg::DATA_W-1:0]  acceleration;

  modport source (output valid, output displacement, output velocity, output acceleration,
                  input ready);
  modport sink   (input valid, input displacement, input velocity, input acceleration,
                  output ready);
endinterface

// File: rtl/nsi_mul.sv
// Multi-cycle Q28.36 multiplier: one 32x32 partial product per cycle, round and saturate.
module nsi_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [nsi_pkg::DATA_W-1:0] op_a,
  input  logic signed [nsi_pkg::DATA_W-1:0] op_b,
  output logic                              busy,
  output logic                              done,
  output logic signed [nsi_pkg::DATA_W-1:0] result
);

  localparam int HALF_W = nsi_pkg::DATA_W / 2;
  localparam int ACC_W  = 2 * nsi_pkg::DATA_W;

  typedef enum logic [1:0] {S_IDLE, S_ACC, S_RND} mstate_t;

  mstate_t                    state_r;
  logic [1:0]                 step_r;
  logic [nsi_pkg::DATA_W-1:0] mag_a_r, mag_b_r;
  logic                       neg_r;
  logic [ACC_W-1:0]           acc_r;
  logic signed [nsi_pkg::DATA_W-1:0] res_r;
  logic                       done_r;

  logic [HALF_W-1:0]          half_a, half_b;
  logic [2*HALF_W-1:0]        pp;
  logic [ACC_W-1:0]           pp_shift;
  logic [nsi_pkg::DATA_W-1:0] mag;
  logic [nsi_pkg::DATA_W-1:0] sat_val;

  function automatic logic [nsi_pkg::DATA_W-1:0] abs_u(input logic [nsi_pkg::DATA_W-1:0] v);
    return v[nsi_pkg::DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  assign half_a = step_r[1] ? mag_a_r[nsi_pkg::DATA_W-1:HALF_W] : mag_a_r[HALF_W-1:0];
  assign half_b = step_r[0] ? mag_b_r[nsi_pkg::DATA_W-1:HALF_W] : mag_b_r[HALF_W-1:0];
  assign pp     = half_a * half_b;

  always_comb begin
    case (step_r)
      2'd0:    pp_shift = {{(ACC_W-2*HALF_W){1'b0}}, pp};
      2'd3:    pp_shift = {pp, {(2*HALF_W){1'b0}}};
      default: pp_shift = {{HALF_W{1'b0}}, pp, {HALF_W{1'b0}}};
    endcase
  end

  // the rounding half was preloaded into the accumulator
  assign mag = acc_r[nsi_pkg::FRAC_W +: nsi_pkg::DATA_W];

  always_comb begin
    if (|acc_r[ACC_W-1:nsi_pkg::FRAC_W+nsi_pkg::DATA_W]) begin
      sat_val = neg_r ? nsi_pkg::SAT_MIN : nsi_pkg::SAT_MAX;
    end else if (!neg_r) begin
      sat_val = mag[nsi_pkg::DATA_W-1] ? nsi_pkg::SAT_MAX : mag;
    end else if (mag[nsi_pkg::DATA_W-1] && |mag[nsi_pkg::DATA_W-2:0]) begin
      sat_val = nsi_pkg::SAT_MIN;
    end else begin
      sat_val = ~mag + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            mag_a_r <= abs_u(op_a);
            mag_b_r <= abs_u(op_b);
            neg_r   <= op_a[nsi_pkg::DATA_W-1] ^ op_b[nsi_pkg::DATA_W-1];
            acc_r   <= ACC_W'(1) << (nsi_pkg::FRAC_W - 1);
            step_r  <= '0;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          acc_r  <= acc_r + pp_shift;
          step_r <= step_r + 1'b1;
          if (step_r == 2'd3) begin
            state_r <= S_RND;
          end
        end
        S_RND: begin
          res_r   <= sat_val;
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state_r != S_IDLE);
  assign done   = done_r;
  assign result = res_r;

endmodule

// File: rtl/nsi_seq.sv
// Microcode sequencer: step counter, program ROM decode and item handshake control.
module nsi_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_xfer,
  input  logic           in_advance,
  input  logic           mul_done,
  input  logic           out_free,
  output logic           idle,
  output logic           adv_held,
  output nsi_pkg::ctrl_t ctrl
);

  typedef enum logic {S_IDLE, S_RUN} sstate_t;

  sstate_t                     state_r;
  logic [nsi_pkg::PC_W-1:0]    pc_r;
  logic                        wait_r;
  logic                        adv_r;
  nsi_pkg::uword_t             uw;
  logic                        run;

  assign uw  = nsi_pkg::nsi_rom(pc_r);
  assign run = (state_r == S_RUN);

  always_comb begin
    ctrl           = '0;
    ctrl.src_a     = uw.src_a;
    ctrl.src_b     = uw.src_b;
    ctrl.dst       = uw.dst;
    ctrl.alu_sub   = (uw.op == nsi_pkg::OP_SUB);
    if (run) begin
      case (uw.op)
        nsi_pkg::OP_MUL: begin
          ctrl.mul_start = !wait_r;
          ctrl.mul_wr    = wait_r && mul_done;
        end
        nsi_pkg::OP_ADD,
        nsi_pkg::OP_SUB:    ctrl.alu_wr   = 1'b1;
        nsi_pkg::OP_COMMIT: ctrl.commit   = 1'b1;
        nsi_pkg::OP_DONE:   ctrl.out_load = out_free;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      wait_r  <= 1'b0;
      adv_r   <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            adv_r   <= in_advance;
            pc_r    <= '0;
            wait_r  <= 1'b0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          case (uw.op)
            nsi_pkg::OP_JNA: pc_r <= adv_r ? pc_r + 1'b1 : uw.target;
            nsi_pkg::OP_MUL: begin
              if (!wait_r) begin
                wait_r <= 1'b1;
              end else if (mul_done) begin
                wait_r <= 1'b0;
                pc_r   <= pc_r + 1'b1;
              end
            end
            nsi_pkg::OP_DONE: begin
              if (out_free) begin
                state_r <= S_IDLE;
              end
            end
            default: pc_r <= pc_r + 1'b1;
          endcase
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign idle     = (state_r == S_IDLE);
  assign adv_held = adv_r;

endmodule

// File: rtl/nsi_dp.sv
// Datapath: oscillator state, scratch registers, saturating adder and result register.
module nsi_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_xfer,
  input  logic signed [nsi_pkg::DATA_W-1:0] in_force,
  input  nsi_pkg::coef_t                    coef,
  input  nsi_pkg::ctrl_t                    ctrl,
  input  logic signed [nsi_pkg::DATA_W-1:0] mul_res,
  output logic signed [nsi_pkg::DATA_W-1:0] opnd_a,
  output logic signed [nsi_pkg::DATA_W-1:0] opnd_b,
  output logic signed [nsi_pkg::DATA_W-1:0] disp_out,
  output logic signed [nsi_pkg::DATA_W-1:0] vel_out,
  output logic signed [nsi_pkg::DATA_W-1:0] acc_out
);

  localparam int W = nsi_pkg::DATA_W;

  logic [W-1:0] force_r;
  logic [W-1:0] y_r, v_r, a_r;
  logic [W-1:0] tmp_r [nsi_pkg::TMP_N];
  logic [W-1:0] dout_r, vout_r, aout_r;
  logic [W-1:0] b_eff;
  logic [W-1:0] sum;
  logic         ovf;
  logic [W-1:0] alu_res;

  function automatic logic [W-1:0] pick(input nsi_pkg::opd_t s);
    logic [W-1:0] r;
    case (s)
      nsi_pkg::OPD_FORCE: r = force_r;
      nsi_pkg::OPD_Y:     r = y_r;
      nsi_pkg::OPD_V:     r = v_r;
      nsi_pkg::OPD_A:     r = a_r;
      nsi_pkg::OPD_T0:    r = tmp_r[0];
      nsi_pkg::OPD_T1:    r = tmp_r[1];
      nsi_pkg::OPD_T2:    r = tmp_r[2];
      nsi_pkg::OPD_T3:    r = tmp_r[3];
      default:            r = coef[s[nsi_pkg::REG_IDX_W-1:0]];
    endcase
    return r;
  endfunction

  assign opnd_a = pick(ctrl.src_a);
  assign opnd_b = pick(ctrl.src_b);

  // subtract as add of the complement plus one; overflow from operand signs
  assign b_eff = ctrl.alu_sub ? ~opnd_b : opnd_b;
  assign sum   = opnd_a + b_eff + W'(ctrl.alu_sub);
  assign ovf   = (opnd_a[W-1] == b_eff[W-1]) && (sum[W-1] != opnd_a[W-1]);
  assign alu_res = ovf ? (opnd_a[W-1] ? nsi_pkg::SAT_MIN : nsi_pkg::SAT_MAX) : sum;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      force_r <= in_force;
    end
    if (ctrl.alu_wr) begin
      tmp_r[ctrl.dst] <= alu_res;
    end else if (ctrl.mul_wr) begin
      tmp_r[ctrl.dst] <= mul_res;
    end
    if (ctrl.out_load) begin
      dout_r <= y_r;
      vout_r <= v_r;
      aout_r <= a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_r <= '0;
      v_r <= '0;
      a_r <= '0;
    end else if (ctrl.commit) begin
      y_r <= tmp_r[2];
      v_r <= tmp_r[1];
      a_r <= tmp_r[3];
    end
  end

  assign disp_out = dout_r;
  assign vel_out  = vout_r;
  assign acc_out  = aout_r;

endmodule

// File: rtl/newmark_sdof_integrator_unit.sv
// Top level of the Newmark single-mass integrator: register port, sequencer and datapath.
//
// Usage:
//   in_ch  carries force_req and advance; one item is taken while the block is idle.
//   out_ch returns displacement, velocity and acceleration after each item.
//   Registers sit on the APB port at byte address 8*i, 64-bit data; write only while idle.
// Sequence:
//   A time step (advance set) runs a 17-step program and a final done word; each of its
//   8 multiplies runs on the single 32x32 partial-product multiplier. A hold item
//   (advance clear) jumps from the first step straight to the done word. in_ready
//   returns together with out_valid, so the next item is taken only once the
//   previous item has loaded its result into the output register.
// Reset:
//   rst_n clears the state and all registers to zero and leaves both channels empty.
// Stall:
//   A finished result waits in the output register; the next item is still taken
//   and runs, and it waits at its last step until the previous result is transferred.
module newmark_sdof_integrator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  nsi_in_if.sink                            in_ch,
  nsi_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nsi_pkg::PADDR_W-1:0]       paddr,
  input  logic [nsi_pkg::DATA_W-1:0]        pwdata,
  output logic [nsi_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  nsi_pkg::coef_t                    coef_r;
  logic [nsi_pkg::REG_IDX_W-1:0]     reg_idx;
  logic                              in_xfer;
  logic                              idle;
  logic                              adv_held;
  logic                              out_valid_r;
  logic                              out_free;
  nsi_pkg::ctrl_t                    ctrl;
  logic signed [nsi_pkg::DATA_W-1:0] opnd_a, opnd_b;
  logic signed [nsi_pkg::DATA_W-1:0] mul_res;
  logic                              mul_busy;
  logic                              mul_done;

  assign reg_idx = paddr[nsi_pkg::PADDR_W-1:3];
  assign pready  = 1'b1;
  assign prdata  = coef_r[reg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (psel && penable && pwrite) begin
      coef_r[reg_idx] <= pwdata;
    end
  end

  assign in_ch.ready = idle && rst_n;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid_r;

  nsi_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_xfer    (in_xfer),
    .in_advance (in_ch.advance),
    .mul_done   (mul_done),
    .out_free   (out_free),
    .idle       (idle),
    .adv_held   (adv_held),
    .ctrl       (ctrl)
  );

  nsi_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctrl.mul_start),
    .op_a   (opnd_a),
    .op_b   (opnd_b),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_res)
  );

  nsi_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_xfer  (in_xfer),
    .in_force (in_ch.force_req),
    .coef     (coef_r),
    .ctrl     (ctrl),
    .mul_res  (mul_res),
    .opnd_a   (opnd_a),
    .opnd_b   (opnd_b),
    .disp_out (out_ch.displacement),
    .vel_out  (out_ch.velocity),
    .acc_out  (out_ch.acceleration)
  );

`ifndef SYNTHESIS
  a_commit_adv: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.commit |-> adv_held)
    else $error("state committed for a hold item");

  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten before transfer");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.mul_start || ctrl.commit) |-> !in_ch.ready)
    else $error("input ready while a step is running");
`endif

endmodule
